// ===== src/krpc_pkg.sv =====
// shared types, constants and helpers for the keyed row permutation cipher
// no dependencies
package krpc_pkg;

  localparam int unsigned MAX_KEY   = 8;
  localparam int unsigned KEY_W     = 64;
  localparam int unsigned LEN_W     = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [7:0]  PAD_CHAR  = 8'h58;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_LETTERS  = 2'd0,
    REG_KEY_LENGTH   = 2'd1,
    REG_DECRYPT_MODE = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    CMD_BYTE  = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e       command;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       row_last;
    logic       message_end;
  } out_item_t;

  typedef struct packed {
    logic             bare;
    logic             is_end;
    logic [LEN_W-1:0] width;
  } job_ctl_t;

  function automatic logic [7:0] to_upper(input logic [7:0] ch);
    logic [7:0] res;
    res = ch;
    if (ch >= 8'h61 && ch <= 8'h7A) begin
      res = ch - 8'h20;
    end
    return res;
  endfunction

endpackage

// ===== src/krpc_rank.sv =====
// stable rank and sorted-order tables of the key, registered
// depends on krpc_pkg
module krpc_rank #(
  parameter int unsigned MaxKey = krpc_pkg::MAX_KEY,
  parameter int unsigned IdxW   = (MaxKey > 1) ? $clog2(MaxKey) : 1
) (
  input  logic                         clk_i,
  input  logic [krpc_pkg::KEY_W-1:0]   key_letters_i,
  input  logic [krpc_pkg::LEN_W-1:0]   width_i,
  output logic [MaxKey-1:0][IdxW-1:0]  rank_o,
  output logic [MaxKey-1:0][IdxW-1:0]  perm_o
);
  import krpc_pkg::*;

  logic [MaxKey-1:0][7:0]      kc;
  logic [MaxKey-1:0][IdxW-1:0] rank_d, rank_q;
  logic [MaxKey-1:0][IdxW-1:0] perm_d, perm_q;

  always_comb begin
    for (int c = 0; c < MaxKey; c++) begin
      kc[c] = to_upper(key_letters_i[8*c +: 8]);
    end
    for (int c = 0; c < MaxKey; c++) begin
      rank_d[c] = '0;
      for (int i = 0; i < MaxKey; i++) begin
        if (LEN_W'(i) < width_i &&
            (kc[i] < kc[c] || (kc[i] == kc[c] && i < c))) begin
          rank_d[c] = rank_d[c] + IdxW'(1);
        end
      end
    end
    perm_d = '0;
    for (int c = 0; c < MaxKey; c++) begin
      if (LEN_W'(c) < width_i) begin
        perm_d[rank_d[c]] = IdxW'(c);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rank_q <= rank_d;
    perm_q <= perm_d;
  end

  assign rank_o = rank_q;
  assign perm_o = perm_q;

endmodule

// ===== src/krpc_front.sv =====
// front end: filters and uppercases bytes, fills the pending row, issues row jobs
// depends on krpc_pkg
module krpc_front #(
  parameter int unsigned MaxKey = krpc_pkg::MAX_KEY,
  parameter int unsigned IdxW   = (MaxKey > 1) ? $clog2(MaxKey) : 1,
  parameter int unsigned CntW   = $clog2(MaxKey + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  krpc_pkg::in_item_t          item_i,
  input  logic [krpc_pkg::LEN_W-1:0]  width_i,
  output logic                        job_push_o,
  output logic [MaxKey-1:0][7:0]      job_data_o,
  output krpc_pkg::job_ctl_t          job_ctl_o
);
  import krpc_pkg::*;

  logic [MaxKey-1:0][7:0] row_q, row_next;
  logic [CntW-1:0]        fill_q, fill_d, fill_inc, fill_eff;
  logic                   is_byte, keep, wr_byte;
  logic [7:0]             ch_up;

  always_comb begin
    is_byte  = (item_i.command == CMD_BYTE);
    keep     = item_i.data_byte inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
    wr_byte  = is_byte && keep;
    ch_up    = to_upper(item_i.data_byte);
    fill_inc = fill_q + CntW'(1);
    fill_eff = is_byte ? fill_inc : fill_q;

    for (int c = 0; c < MaxKey; c++) begin
      row_next[c] = row_q[c];
      if (wr_byte && fill_q[IdxW-1:0] == IdxW'(c)) begin
        row_next[c] = ch_up;
      end
      job_data_o[c] = (CntW'(c) < fill_eff) ? row_next[c] : PAD_CHAR;
    end

    job_ctl_o.bare   = !is_byte && (fill_q == '0);
    job_ctl_o.is_end = !is_byte;
    job_ctl_o.width  = width_i;

    job_push_o = accept_i && (!is_byte || (keep && LEN_W'(fill_inc) >= width_i));

    fill_d = fill_q;
    if (job_push_o) begin
      fill_d = '0;
    end else if (accept_i && wr_byte) begin
      fill_d = fill_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && wr_byte) begin
      row_q <= row_next;
    end
  end

endmodule

// ===== src/krpc_jobq.sv =====
// two-entry queue of row jobs between front and back
// depends on krpc_pkg
module krpc_jobq #(
  parameter int unsigned MaxKey = krpc_pkg::MAX_KEY
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  logic [MaxKey-1:0][7:0]  data_i,
  input  krpc_pkg::job_ctl_t      ctl_i,
  input  logic                    deq_i,
  output logic                    full_o,
  output logic                    valid_o,
  output logic [MaxKey-1:0][7:0]  data_o,
  output krpc_pkg::job_ctl_t      ctl_o
);
  import krpc_pkg::*;

  logic [1:0][MaxKey-1:0][7:0] data_q;
  job_ctl_t [1:0]              ctl_q;
  logic                        wr_ptr_q, rd_ptr_q;
  logic [1:0]                  count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = data_q[rd_ptr_q];
  assign ctl_o   = ctl_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (deq_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + {1'b0, push_i} - {1'b0, deq_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q[wr_ptr_q] <= data_i;
      ctl_q[wr_ptr_q]  <= ctl_i;
    end
  end

endmodule

// ===== src/krpc_back.sv =====
// back end: walks a row job one column per cycle into the output register
// when that register is free or popped; depends on krpc_pkg
module krpc_back #(
  parameter int unsigned MaxKey = krpc_pkg::MAX_KEY,
  parameter int unsigned IdxW   = (MaxKey > 1) ? $clog2(MaxKey) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        job_valid_i,
  input  logic [MaxKey-1:0][7:0]      job_data_i,
  input  krpc_pkg::job_ctl_t          job_ctl_i,
  input  logic [MaxKey-1:0][IdxW-1:0] rank_i,
  input  logic [MaxKey-1:0][IdxW-1:0] perm_i,
  input  logic                        decrypt_i,
  input  logic                        pop_i,
  output logic                        deq_o,
  output logic                        empty_o,
  output krpc_pkg::out_item_t         item_o
);
  import krpc_pkg::*;

  logic [IdxW-1:0] col_q, col_d, src;
  logic            out_v_q, out_v_d, load, last;
  out_item_t       res, out_q;

  always_comb begin
    load = job_valid_i && (!out_v_q || pop_i);
    src  = decrypt_i ? rank_i[col_q] : perm_i[col_q];
    last = job_ctl_i.bare || (LEN_W'(col_q) + LEN_W'(1) == job_ctl_i.width);

    if (job_ctl_i.bare) begin
      res.out_char   = 8'h00;
      res.char_valid = 1'b0;
    end else begin
      res.out_char   = job_data_i[src];
      res.char_valid = 1'b1;
    end
    res.row_last    = last;
    res.message_end = last && job_ctl_i.is_end;

    deq_o = load && last;
    col_d = col_q;
    if (load) begin
      col_d = last ? '0 : col_q + IdxW'(1);
    end
    out_v_d = out_v_q;
    if (load) begin
      out_v_d = 1'b1;
    end else if (pop_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      col_q   <= col_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

  assign empty_o = !out_v_q;
  assign item_o  = out_q;

endmodule

// ===== src/keyed_row_permutation_cipher.sv =====
// top level of the keyed row permutation cipher: config registers, front, job queue, back
// depends on krpc_pkg, krpc_rank, krpc_front, krpc_jobq, krpc_back
//
// usage
// - input side is a queue: present in_item_i with push; a transfer happens when
//   push is high and full is low. full rises while two row jobs are waiting.
// - result side is a queue: while empty is low the oldest result is on
//   out_item_o; a transfer happens when pop is high and empty is low.
// - config: cfg_valid_i with cfg_index_i and cfg_data_i, always ready. write only
//   while the block is idle.
// - a byte that completes a row, or a flush, is written to the job queue and
//   then loaded into the output register; a row of w columns then drains one
//   result per cycle while the receiver pops. other bytes give nothing.
// - inputs are taken one per cycle while the two-entry job queue has room; the
//   back end handles one column at a time, which sets the sustained rate.
// - if the receiver stalls, the output register holds, the back end stops and
//   full rises once the job queue holds two rows; nothing is lost.
// - reset empties the row, the job queue and the output register and restores
//   key length 1, encrypt mode and an all-zero key.
module keyed_row_permutation_cipher #(
  parameter int unsigned MaxKey = krpc_pkg::MAX_KEY
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  krpc_pkg::in_item_t                  in_item_i,
  output logic                                empty,
  input  logic                                pop,
  output krpc_pkg::out_item_t                 out_item_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [krpc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [krpc_pkg::KEY_W-1:0]          cfg_data_i
);
  import krpc_pkg::*;

  localparam int unsigned IdxW = (MaxKey > 1) ? $clog2(MaxKey) : 1;

  logic [KEY_W-1:0]            key_letters_q;
  logic [LEN_W-1:0]            key_length_q, width;
  logic                        decrypt_q;
  logic                        accept, job_push, job_full, job_valid, job_deq;
  logic [MaxKey-1:0][7:0]      push_data, head_data;
  job_ctl_t                    push_ctl, head_ctl;
  logic [MaxKey-1:0][IdxW-1:0] rank, perm;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_letters_q <= '0;
      key_length_q  <= LEN_W'(1);
      decrypt_q     <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_KEY_LETTERS:  key_letters_q <= cfg_data_i;
        REG_KEY_LENGTH:   key_length_q  <= cfg_data_i[LEN_W-1:0];
        REG_DECRYPT_MODE: decrypt_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (key_length_q == '0) begin
      width = LEN_W'(1);
    end else if (key_length_q > LEN_W'(MaxKey)) begin
      width = LEN_W'(MaxKey);
    end else begin
      width = key_length_q;
    end
  end

  assign full   = job_full;
  assign accept = push && !job_full;

  krpc_rank #(.MaxKey(MaxKey), .IdxW(IdxW)) u_rank (
    .clk_i         (clk_i),
    .key_letters_i (key_letters_q),
    .width_i       (width),
    .rank_o        (rank),
    .perm_o        (perm)
  );

  krpc_front #(.MaxKey(MaxKey), .IdxW(IdxW)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (in_item_i),
    .width_i    (width),
    .job_push_o (job_push),
    .job_data_o (push_data),
    .job_ctl_o  (push_ctl)
  );

  krpc_jobq #(.MaxKey(MaxKey)) u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (push_data),
    .ctl_i   (push_ctl),
    .deq_i   (job_deq),
    .full_o  (job_full),
    .valid_o (job_valid),
    .data_o  (head_data),
    .ctl_o   (head_ctl)
  );

  krpc_back #(.MaxKey(MaxKey), .IdxW(IdxW)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_data_i  (head_data),
    .job_ctl_i   (head_ctl),
    .rank_i      (rank),
    .perm_i      (perm),
    .decrypt_i   (decrypt_q),
    .pop_i       (pop),
    .deq_o       (job_deq),
    .empty_o     (empty),
    .item_o      (out_item_o)
  );

`ifndef SYNTHESIS
  a_row_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !empty && !out_item_o.row_last |=> !empty)
    else $error("row burst broken after transfer");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_item_o.message_end |-> out_item_o.row_last)
    else $error("message end without row last");

  a_bare_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !out_item_o.char_valid |->
      out_item_o.message_end && out_item_o.out_char == 8'h00)
    else $error("malformed end marker");
`endif

endmodule
